// ===== sv/bsm_pkg.sv =====
// Shared types and constants for the radix-2 Booth signed multiplier.
`default_nettype none

package bsm_pkg;

    // Fixed widths of the ports.
    localparam int OPND_W = 16;
    localparam int PROD_W = 32;
    localparam int CFG_W  = 5;

    // Default operand width limit and reset value of the width register.
    localparam int               MAX_WIDTH_DEF = 16;
    localparam logic [CFG_W-1:0] CFG_RESET     = 5'd16;

    // Booth recoding of the pair {current multiplier bit, previous bit}.
    localparam logic [1:0] BOOTH_SUB = 2'b10;
    localparam logic [1:0] BOOTH_ADD = 2'b01;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic out_load;
    } t_dp_cmd;

endpackage

`default_nettype wire

// ===== sv/bsm_datapath.sv =====
// Datapath of the Booth multiplier: width register, accumulator, shift register, result.
`default_nettype none

module bsm_datapath #(
    parameter int MAX_WIDTH = bsm_pkg::MAX_WIDTH_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire  [bsm_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire  bsm_pkg::t_dp_cmd       i_cmd,
    input  wire  [bsm_pkg::OPND_W-1:0]   i_multiplicand,
    input  wire  [bsm_pkg::OPND_W-1:0]   i_multiplier,
    output logic signed [bsm_pkg::PROD_W-1:0] o_product
);
    import bsm_pkg::*;

    localparam int W  = MAX_WIDTH;
    localparam int AW = W + 1;
    localparam int PW = 2 * W + 1;
    localparam logic [5:0] W_LIM = 6'(W);

    logic [CFG_W-1:0]        r_width;
    logic [AW-1:0]           r_acc, n_acc;
    logic [AW-1:0]           r_m,   n_m;
    logic [W-1:0]            r_q,   n_q;
    logic                    r_prev, n_prev;
    logic signed [PROD_W-1:0] r_product;

    logic [5:0]        n_eff;
    logic [W-1:0]      mcand_z, mplier_z, mcand_x, mplier_x;
    logic              mcand_sgn, mplier_sgn;
    logic [AW-1:0]     sum;
    logic signed [PW-1:0] full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_width <= i_cfg_data;
        end
    end

    // Effective operand width: zero counts as one, large values saturate.
    always_comb begin
        if (r_width == '0) begin
            n_eff = 6'd1;
        end else if ({1'b0, r_width} > W_LIM) begin
            n_eff = W_LIM;
        end else begin
            n_eff = {1'b0, r_width};
        end
    end

    // Sign-extend both operands from the effective width to the full width.
    // The Booth pass then always runs over all W bits and gives the same product.
    always_comb begin
        mcand_z    = W'(i_multiplicand);
        mplier_z   = W'(i_multiplier);
        mcand_sgn  = 1'b0;
        mplier_sgn = 1'b0;
        for (int i = 0; i < W; i++) begin
            if (6'(i) == n_eff - 6'd1) begin
                mcand_sgn  = mcand_z[i];
                mplier_sgn = mplier_z[i];
            end
        end
        for (int i = 0; i < W; i++) begin
            mcand_x[i]  = (6'(i) < n_eff) ? mcand_z[i]  : mcand_sgn;
            mplier_x[i] = (6'(i) < n_eff) ? mplier_z[i] : mplier_sgn;
        end
    end

    always_comb begin
        case ({r_q[0], r_prev})
            BOOTH_SUB: sum = r_acc - r_m;
            BOOTH_ADD: sum = r_acc + r_m;
            default:   sum = r_acc;
        endcase
    end

    always_comb begin
        n_acc  = r_acc;
        n_m    = r_m;
        n_q    = r_q;
        n_prev = r_prev;
        if (i_cmd.load) begin
            n_acc  = '0;
            n_m    = {mcand_x[W-1], mcand_x};
            n_q    = mplier_x;
            n_prev = 1'b0;
        end else if (i_cmd.step) begin
            n_acc  = {sum[AW-1], sum[AW-1:1]};
            n_q    = {sum[0], r_q[W-1:1]};
            n_prev = r_q[0];
        end
    end

    assign full = $signed({r_acc, r_q});

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_m    <= n_m;
        r_q    <= n_q;
        r_prev <= n_prev;
        if (i_cmd.out_load) begin
            r_product <= PROD_W'(full);
        end
    end

    assign o_product = r_product;

endmodule

`default_nettype wire

// ===== sv/bsm_ctrl.sv =====
// Controller of the Booth multiplier: state machine, step counter and result valid.
`default_nettype none

module bsm_ctrl #(
    parameter int MAX_WIDTH = bsm_pkg::MAX_WIDTH_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire                    i_out_ready,
    output bsm_pkg::t_dp_cmd       o_cmd
);
    import bsm_pkg::*;

    localparam int            CNT_W = $clog2(MAX_WIDTH);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(MAX_WIDTH - 1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt,   n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             out_free;
    logic             in_ready;
    t_dp_cmd          cmd;

    assign out_free = !r_out_valid || i_out_ready;

    // Output decode.
    always_comb begin
        in_ready     = 1'b0;
        cmd.step     = 1'b0;
        cmd.out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                in_ready = 1'b1;
            end
            ST_CALC: begin
                cmd.step = 1'b1;
            end
            ST_DONE: begin
                in_ready     = out_free;
                cmd.out_load = out_free;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
        cmd.load = i_in_valid && in_ready;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_CALC;
            end
            ST_CALC: begin
                if (r_cnt == LAST) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) n_state = i_in_valid ? ST_CALC : ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_cnt = r_cnt;
        if (cmd.load) begin
            n_cnt = '0;
        end else if (cmd.step) begin
            n_cnt = r_cnt + CNT_W'(1);
        end
        n_out_valid = r_out_valid;
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    // A new beat must never overwrite operands of a product still in progress.
    a_no_load_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CALC |-> !cmd.load)
        else $error("operand load during Booth steps");

    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> (r_state == ST_CALC && r_cnt == '0))
        else $error("load did not start a fresh pass");

    a_last_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CALC && r_cnt == LAST) |=> r_state == ST_DONE)
        else $error("pass did not end after the last step");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !cmd.out_load)
        else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

// ===== sv/booth_signed_multiplier_top.sv =====
// Top level of the radix-2 Booth signed multiplier.
//
//  Channel  Direction  Handshake                 Payload
//  input    in         i_in_valid / o_in_ready   i_multiplicand, i_multiplier
//  result   out        o_out_valid / i_out_ready o_product
//  config   in         i_cfg_we                  i_cfg_data (operand width)
//
// Each beat loads its operands and then runs MAX_WIDTH add-and-shift steps on the
// shared adder; a new beat is taken only in the idle or done state, not while the
// steps of the previous beat run.
// Reset is synchronous, active low, and sets the operand width to 16.
// A result not taken sits in the output register; the next beat is still taken
// and computed, and only waits at its end until that register is free.
`default_nettype none

module booth_signed_multiplier_top #(
    parameter int MAX_WIDTH = bsm_pkg::MAX_WIDTH_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire  [bsm_pkg::CFG_W-1:0]         i_cfg_data,
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire  [bsm_pkg::OPND_W-1:0]        i_multiplicand,
    input  wire  [bsm_pkg::OPND_W-1:0]        i_multiplier,
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output logic signed [bsm_pkg::PROD_W-1:0] o_product
);
    import bsm_pkg::*;

    t_dp_cmd cmd;

    bsm_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    bsm_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (cmd),
        .i_multiplicand (i_multiplicand),
        .i_multiplier   (i_multiplier),
        .o_product      (o_product)
    );

endmodule

`default_nettype wire
